>>> rtl/battery_remaining_time_estimator_defines.svh
// Assertion macros for the battery runtime estimator.
// No dependencies; the including module must provide clk and rst_n.
`ifndef BATTERY_REMAINING_TIME_ESTIMATOR_DEFINES_SVH
`define BATTERY_REMAINING_TIME_ESTIMATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define BRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define BRE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BRE_ASSERT(lbl, prop, msg)
`define BRE_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/bre_pkg.sv
// Shared types and constants of the battery runtime estimator.
// No dependencies.
package bre_pkg;

    localparam int CUR_W = 24;
    localparam int PCT_W = 7;
    localparam int CAP_W = 13;
    localparam int DEF_W = 23;
    localparam int SEC_W = 29;
    localparam int AVG_W = 14;   // |average mA| stays below 8389
    localparam int CHG_W = 26;   // 36 * capacity * percent
    localparam int PROD_W = CAP_W + PCT_W;

    localparam int UA_PER_MA = 1000;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd3000;
    localparam logic [DEF_W-1:0] DEFAULT_UA_RESET = 23'd200000;
    localparam logic signed [SEC_W-1:0] ESTIMATE_INVALID = -29'sd1;

    typedef enum logic
    {
        REG_CAPACITY,
        REG_DEFAULT_CURRENT
    } cfg_reg_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_SCALE,
        ST_TOTAL,
        ST_AVG_GO,
        ST_DIV_AVG,
        ST_TIME_GO,
        ST_DIV_TIME,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic                    discharging;
        logic signed [CUR_W-1:0] current_ua;
        logic [PCT_W-1:0]        charge_percent;
    } sample_t;

    typedef struct packed
    {
        logic signed [SEC_W-1:0] remaining_seconds;
        logic                    estimate_changed;
    } estimate_t;

endpackage

>>> rtl/bre_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bre_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 300
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bre_div.sv
// Bit-serial restoring divider, unsigned, one quotient bit per cycle.
// No dependencies; the dividend is given left-aligned for short runs.
module bre_div #(
    parameter int DVD_W = 34,
    parameter int DVS_W = 19,
    parameter int STEP_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] steps,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              busy,
    output logic              done,
    output logic [DVD_W-1:0]  quotient
);

    logic [DVD_W-1:0]  dq_reg, dq_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    // shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, dq_reg[DVD_W-1]} - {1'b0, dvs_reg};
    assign fits = !trial[DVS_W];

    always_comb
    begin
        dq_next = dq_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next = dividend;
            rem_next = '0;
            cnt_next = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dq_next = {dq_reg[DVD_W-2:0], fits};
            rem_next = fits ? trial[DVS_W-1:0] : {rem_reg[DVS_W-2:0], dq_reg[DVD_W-1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg <= dq_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = dq_reg;

endmodule

>>> rtl/bre_cfg.sv
// APB-style register file: nominal capacity and default current.
// Depends on bre_pkg.
module bre_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bre_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bre_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bre_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [bre_pkg::CAP_W-1:0]         capacity_mah,
    output logic [bre_pkg::DEF_W-1:0]         default_ua
);

    logic [bre_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [bre_pkg::DEF_W-1:0] def_reg, def_next;
    logic                      wr_en;
    bre_pkg::cfg_reg_t         sel;

    assign wr_en = psel && penable && pwrite;
    assign sel = bre_pkg::cfg_reg_t'(paddr[2]);

    always_comb
    begin
        cap_next = cap_reg;
        def_next = def_reg;
        prdata = '0;
        unique case (sel)
            bre_pkg::REG_CAPACITY:
            begin
                prdata = {{(bre_pkg::APB_DATA_W-bre_pkg::CAP_W){1'b0}}, cap_reg};
                if (wr_en)
                begin
                    cap_next = pwdata[bre_pkg::CAP_W-1:0];
                end
            end
            bre_pkg::REG_DEFAULT_CURRENT:
            begin
                prdata = {{(bre_pkg::APB_DATA_W-bre_pkg::DEF_W){1'b0}}, def_reg};
                if (wr_en)
                begin
                    def_next = pwdata[bre_pkg::DEF_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bre_pkg::CAP_RESET;
            def_reg <= bre_pkg::DEFAULT_UA_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
            def_reg <= def_next;
        end
    end

    assign pready = 1'b1;
    assign capacity_mah = cap_reg;
    assign default_ua = def_reg;

endmodule

>>> rtl/battery_remaining_time_estimator.sv
// Top level of the battery runtime estimator: sequencer, window state, output register.
// Depends on bre_pkg, bre_ram, bre_div, bre_cfg and the assertion macro header.
//
//  channel    | direction | handshake                  | payload
//  -----------+-----------+----------------------------+----------------------------
//  sample     | in        | sample_valid / sample_stall  | bre_pkg::sample_t
//  estimate   | out       | estimate_valid / estimate_stall | bre_pkg::estimate_t
//  apb        | in/out    | psel, penable, pready        | paddr, pwdata, prdata
//
// A discharging item passes ST_READ, ST_SUM, ST_SCALE and ST_TOTAL, then two bit-serial
// divisions on the shared divider, one for the average current and one for the runtime,
// before ST_DONE; a zero average skips the second division. A non-discharging item goes
// from ST_IDLE straight to ST_DONE. One item is in work at a time; the next is taken
// once a result is loaded and the sequencer is back in ST_IDLE, even while that result
// waits in the output register.
// Reset clears the sequencer, slot pointer, fill count, sum and held estimate; the
// sample ring needs no clearing pass, as a slot's old value is only used once written.
// A stalled result holds in the output register; a finished item waits in the last
// state until that register is free.
`include "battery_remaining_time_estimator_defines.svh"

module battery_remaining_time_estimator #(
    parameter int WINDOW = 300
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  bre_pkg::sample_t               sample,
    output logic                           estimate_valid,
    input  logic                           estimate_stall,
    output bre_pkg::estimate_t             estimate,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bre_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bre_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bre_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W = bre_pkg::CUR_W + $clog2(WINDOW);
    localparam int TOT_W = SUM_W + 1;
    localparam int BIAS_W = FILL_W + bre_pkg::DEF_W;
    localparam int DIV_CONST = WINDOW * bre_pkg::UA_PER_MA;
    localparam int DIV_CONST_W = $clog2(DIV_CONST + 1);
    localparam int DVS_W = (DIV_CONST_W > bre_pkg::AVG_W) ? DIV_CONST_W : bre_pkg::AVG_W;
    localparam int STEP_W = $clog2(TOT_W + 1);

    // configuration
    logic [bre_pkg::CAP_W-1:0] capacity_mah;
    logic [bre_pkg::DEF_W-1:0] default_ua;

    // sequencer
    bre_pkg::state_t state_reg, state_next;
    logic            sample_accept;
    logic            load_out;

    // window state
    bre_pkg::sample_t         sample_reg;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  cur_ext, old_ext;
    logic                     window_full;

    // arithmetic pipeline
    logic [BIAS_W-1:0]           bias_reg;
    logic [FILL_W-1:0]           empty_slots;
    logic [bre_pkg::PROD_W-1:0]  prod_reg;
    logic [bre_pkg::CHG_W-1:0]   charge_reg;
    logic signed [TOT_W-1:0]     total_reg;
    logic [TOT_W-1:0]            total_mag;
    logic [bre_pkg::AVG_W-1:0]   avg_mag_reg;
    logic                        avg_neg_reg;
    logic [bre_pkg::SEC_W-1:0]   secs_mag;

    // result
    logic signed [bre_pkg::SEC_W-1:0] held_reg, held_next;
    logic                             changed_reg, changed_next;
    logic                             est_valid_reg, est_valid_next;
    bre_pkg::estimate_t               est_reg;

    // ring memory
    logic                        ram_en;
    logic                        ram_we;
    logic [bre_pkg::CUR_W-1:0]   ram_rdata;

    // divider
    logic              div_start;
    logic [STEP_W-1:0] div_steps;
    logic [TOT_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [TOT_W-1:0]  div_quotient;

    bre_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .capacity_mah (capacity_mah),
        .default_ua   (default_ua)
    );

    bre_ram #(
        .WIDTH (bre_pkg::CUR_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (slot_reg),
        .wdata (sample_reg.current_ua),
        .rdata (ram_rdata)
    );

    bre_div #(
        .DVD_W  (TOT_W),
        .DVS_W  (DVS_W),
        .STEP_W (STEP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign sample_accept = sample_valid && !sample_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bre_pkg::ST_IDLE:
            begin
                if (sample_accept)
                begin
                    state_next = sample.discharging ? bre_pkg::ST_READ : bre_pkg::ST_DONE;
                end
            end
            bre_pkg::ST_READ:     state_next = bre_pkg::ST_SUM;
            bre_pkg::ST_SUM:      state_next = bre_pkg::ST_SCALE;
            bre_pkg::ST_SCALE:    state_next = bre_pkg::ST_TOTAL;
            bre_pkg::ST_TOTAL:    state_next = bre_pkg::ST_AVG_GO;
            bre_pkg::ST_AVG_GO:   state_next = bre_pkg::ST_DIV_AVG;
            bre_pkg::ST_DIV_AVG:
            begin
                if (div_done)
                begin
                    state_next = bre_pkg::ST_TIME_GO;
                end
            end
            bre_pkg::ST_TIME_GO:
            begin
                state_next = (avg_mag_reg == '0) ? bre_pkg::ST_DONE : bre_pkg::ST_DIV_TIME;
            end
            bre_pkg::ST_DIV_TIME:
            begin
                if (div_done)
                begin
                    state_next = bre_pkg::ST_DONE;
                end
            end
            bre_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = bre_pkg::ST_IDLE;
                end
            end
            default:              state_next = bre_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        sample_stall = 1'b1;
        ram_en = 1'b0;
        ram_we = 1'b0;
        div_start = 1'b0;
        div_steps = STEP_W'(TOT_W);
        div_dividend = total_mag;
        div_divisor = DVS_W'(DIV_CONST);
        load_out = 1'b0;
        unique case (state_reg)
            bre_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
            end
            bre_pkg::ST_READ:
            begin
                ram_en = 1'b1;
            end
            bre_pkg::ST_SUM:
            begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            bre_pkg::ST_AVG_GO:
            begin
                div_start = 1'b1;
            end
            bre_pkg::ST_TIME_GO:
            begin
                // left-align the charge so the run takes only its own width
                div_start = (avg_mag_reg != '0);
                div_steps = STEP_W'(bre_pkg::CHG_W);
                div_dividend = TOT_W'(charge_reg) << (TOT_W - bre_pkg::CHG_W);
                div_divisor = DVS_W'(avg_mag_reg);
            end
            bre_pkg::ST_DONE:
            begin
                load_out = !est_valid_reg || !estimate_stall;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    // Window update: drop the oldest sample once the ring is full, add the new one
    assign window_full = (fill_reg == FILL_W'(WINDOW));
    assign cur_ext = SUM_W'(sample_reg.current_ua);
    assign old_ext = SUM_W'($signed(ram_rdata));

    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        sum_next = sum_reg;
        held_next = held_reg;
        changed_next = changed_reg;
        if (state_reg == bre_pkg::ST_IDLE && sample_accept)
        begin
            changed_next = sample.discharging || (fill_reg != '0);
            if (!sample.discharging && fill_reg != '0)
            begin
                slot_next = '0;
                fill_next = '0;
                sum_next = '0;
                held_next = bre_pkg::ESTIMATE_INVALID;
            end
        end
        else if (state_reg == bre_pkg::ST_SUM)
        begin
            sum_next = sum_reg + cur_ext - (window_full ? old_ext : SUM_W'(0));
            if (!window_full)
            begin
                fill_next = fill_reg + 1'b1;
            end
            slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
        end
        else if (state_reg == bre_pkg::ST_TIME_GO && avg_mag_reg == '0)
        begin
            held_next = '0;
        end
        else if (state_reg == bre_pkg::ST_DIV_TIME && div_done)
        begin
            held_next = avg_neg_reg ? -$signed(secs_mag) : $signed(secs_mag);
        end
    end

    assign secs_mag = bre_pkg::SEC_W'(div_quotient[bre_pkg::CHG_W-1:0]);

    // Unfilled slots count at the default current
    assign empty_slots = FILL_W'(WINDOW) - fill_reg;
    assign total_mag = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            sample_reg <= sample;
        end
        if (state_reg == bre_pkg::ST_SCALE)
        begin
            bias_reg <= {{bre_pkg::DEF_W{1'b0}}, empty_slots}
                        * {{FILL_W{1'b0}}, default_ua};
            prod_reg <= bre_pkg::PROD_W'(capacity_mah) * bre_pkg::PROD_W'(sample_reg.charge_percent);
        end
        if (state_reg == bre_pkg::ST_TOTAL)
        begin
            total_reg <= TOT_W'(sum_reg) + $signed({{(TOT_W-BIAS_W){1'b0}}, bias_reg});
            // times 36 as 32 plus 4
            charge_reg <= (bre_pkg::CHG_W'(prod_reg) << 5) + (bre_pkg::CHG_W'(prod_reg) << 2);
        end
        if (state_reg == bre_pkg::ST_DIV_AVG && div_done)
        begin
            avg_mag_reg <= div_quotient[bre_pkg::AVG_W-1:0];
            avg_neg_reg <= total_reg[TOT_W-1];
        end
        if (load_out)
        begin
            est_reg.remaining_seconds <= held_reg;
            est_reg.estimate_changed <= changed_reg;
        end
    end

    // Hold a result until taken; take a fresh one once the register frees
    always_comb
    begin
        est_valid_next = est_valid_reg;
        if (load_out)
        begin
            est_valid_next = 1'b1;
        end
        else if (est_valid_reg && !estimate_stall)
        begin
            est_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bre_pkg::ST_IDLE;
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg <= '0;
            held_reg <= bre_pkg::ESTIMATE_INVALID;
            changed_reg <= 1'b0;
            est_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            sum_reg <= sum_next;
            held_reg <= held_next;
            changed_reg <= changed_next;
            est_valid_reg <= est_valid_next;
        end
    end

    assign estimate_valid = est_valid_reg;
    assign estimate = est_reg;

    `BRE_ASSERT_NEVER(a_fill_bound, fill_reg > FILL_W'(WINDOW), "fill count beyond window")
    `BRE_ASSERT_NEVER(a_slot_bound, slot_reg > SLOT_W'(WINDOW - 1), "write slot beyond window")
    `BRE_ASSERT(a_empty_sum, (fill_reg == '0) |-> (sum_reg == '0), "sum not clear on empty window")
    `BRE_ASSERT(a_div_live, (state_reg == bre_pkg::ST_DIV_AVG || state_reg == bre_pkg::ST_DIV_TIME) |-> (div_busy || div_done), "waiting on idle divider")

endmodule

>>> tb/battery_remaining_time_estimator_tb.sv
// Self-checking testbench for the battery runtime estimator: a directed table of items,
// then long random discharge runs under four idling mixes, each result checked in order.
// Depends on bre_pkg and battery_remaining_time_estimator; the expected estimates come
// from an in-line predictor of the moving-average window.
`timescale 1ns / 100ps

module battery_remaining_time_estimator_tb;

    localparam int WINDOW = 300;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    // allow room for two discharging items after the last result
    localparam int DRAIN_CYCLES = 150;
    localparam int LONG_HOLD_CYCLES = 800;
    localparam int HOLD_SPACING = 950;
    localparam int RANDOM_PHASES = 4;
    localparam int ITEMS_PER_PHASE = 445;
    localparam int DIRECTED_ROWS = 21;

    localparam longint SECONDS_PER_HOUR = 3600;
    localparam longint PERCENT_FULL = 100;
    localparam longint WINDOW_UA = longint'(WINDOW) * bre_pkg::UA_PER_MA;
    localparam int CUR_MAX = 8388607;
    localparam int CUR_MIN = -8388608;
    localparam logic signed [bre_pkg::SEC_W-1:0] HELD_INVALID = -29'sd1;

    // One row of the directed table: an optional register load before the item, the item
    // itself, and a hand-worked estimate where it can be read off at a glance.
    typedef struct packed
    {
        logic                             set_cfg;
        logic [bre_pkg::CAP_W-1:0]        cap;
        logic [bre_pkg::DEF_W-1:0]        dflt;
        logic                             dis;
        logic signed [bre_pkg::CUR_W-1:0] cur;
        logic [bre_pkg::PCT_W-1:0]        pct;
        logic                             typed;
        logic signed [bre_pkg::SEC_W-1:0] want_sec;
        logic                             want_chg;
    } directed_row_t;

    // An item waiting to be offered, with its hand-worked estimate if it has one.
    typedef struct packed
    {
        bre_pkg::sample_t   smp;
        logic               typed;
        bre_pkg::estimate_t want;
    } queued_sample_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             sample_valid = 1'b0;
    logic                             sample_stall;
    bre_pkg::sample_t                 sample = '0;
    logic                             estimate_valid;
    logic                             estimate_stall = 1'b0;
    bre_pkg::estimate_t               estimate;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [bre_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [bre_pkg::APB_DATA_W-1:0]   pwdata = '0;
    logic [bre_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    // Predictor copy of the window, the held estimate and the two registers
    int                               ring_ua [WINDOW];
    int                               next_slot = 0;
    int                               filled = 0;
    longint                           run_sum = 0;
    logic signed [bre_pkg::SEC_W-1:0] est_hold = HELD_INVALID;
    logic [bre_pkg::CAP_W-1:0]        cap_mah = bre_pkg::CAP_RESET;
    logic [bre_pkg::DEF_W-1:0]        dflt_ua = bre_pkg::DEFAULT_UA_RESET;

    queued_sample_t                   queued_samples[$];
    bre_pkg::estimate_t               pending_estimates[$];
    queued_sample_t                   on_bus;
    bre_pkg::estimate_t               predicted;
    bre_pkg::estimate_t               wanted;
    int                               send_idle_pct = 0;
    int                               recv_stall_pct = 0;
    int                               results_seen = 0;
    int                               hold_left = 0;
    int                               hold_next = 150;
    int                               error_count = 0;

    // Directed items: reset state, field extremes, zero capacity, zero and negative
    // averages, percent above 100, idle while not discharging and the clear on leaving
    // discharge. Rows without a typed estimate go through the predictor.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b1, 13'd3000, 23'd200000, 1'b0, 24'sd0, 7'd0, 1'b1, -29'sd1, 1'b0},
        '{1'b0, '0, '0, 1'b1, 24'sd200000, 7'd100, 1'b1, 29'sd54000, 1'b1},
        '{1'b0, '0, '0, 1'b1, 24'sh7FFFFF, 7'd127, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 1'b1, 24'sh800000, 7'd1, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 1'b1, 24'sd0, 7'd0, 1'b1, 29'sd0, 1'b1},
        '{1'b0, '0, '0, 1'b0, 24'sd0, 7'd0, 1'b1, -29'sd1, 1'b1},
        '{1'b0, '0, '0, 1'b0, -24'sd1, 7'd127, 1'b1, -29'sd1, 1'b0},
        '{1'b1, 13'd0, 23'h7FFFFF, 1'b1, 24'sd555, 7'd100, 1'b1, 29'sd0, 1'b1},
        '{1'b0, '0, '0, 1'b0, 24'sd0, 7'd0, 1'b1, -29'sd1, 1'b1},
        '{1'b1, 13'h1FFF, 23'd0, 1'b1, 24'sd299999, 7'd127, 1'b1, 29'sd0, 1'b1},
        '{1'b0, '0, '0, 1'b1, 24'sd1, 7'd127, 1'b1, 29'sd37449252, 1'b1},
        '{1'b0, '0, '0, 1'b1, 24'sh800000, 7'd127, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 1'b0, 24'sd0, 7'd0, 1'b1, -29'sd1, 1'b1},
        '{1'b1, 13'd5000, 23'h7FFFFF, 1'b1, 24'sh7FFFFF, 7'd100, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 1'b1, 24'sh800000, 7'd64, 1'b0, '0, 1'b0},
        '{1'b1, 13'd1, 23'd1, 1'b0, 24'sd0, 7'd0, 1'b1, -29'sd1, 1'b1},
        '{1'b0, '0, '0, 1'b1, -24'sd300000, 7'd100, 1'b1, 29'sd0, 1'b1},
        '{1'b0, '0, '0, 1'b1, 24'sh800000, 7'd100, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 1'b1, 24'sh555555, 7'h2A, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 1'b1, 24'shAAAAAA, 7'h55, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 1'b0, 24'sh7FFFFF, 7'h7F, 1'b1, -29'sd1, 1'b1}
    };

    battery_remaining_time_estimator #(
        .WINDOW(WINDOW)
    ) DUT (
        .clk,
        .rst_n,
        .sample_valid,
        .sample_stall,
        .sample,
        .estimate_valid,
        .estimate_stall,
        .estimate,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance the window by one item and return the estimate it should produce.
    // Each division truncates toward zero, as signed longint division does.
    function automatic bre_pkg::estimate_t runtime_after_sample(bre_pkg::sample_t s);
        longint             total;
        longint             avg_ma;
        longint             charge;
        bre_pkg::estimate_t r;
        r.estimate_changed = 1'b0;
        if (s.discharging)
        begin
            // once the window is full, drop the oldest sample from the sum
            if (filled < WINDOW)
                filled++;
            else
                run_sum -= ring_ua[next_slot];
            ring_ua[next_slot] = s.current_ua;
            run_sum += s.current_ua;
            // slots not yet filled count as the default current
            total = run_sum;
            if (filled < WINDOW)
                total += longint'(WINDOW - filled) * longint'(dflt_ua);
            avg_ma = total / WINDOW_UA;
            charge = SECONDS_PER_HOUR * longint'(cap_mah) * longint'(s.charge_percent)
                     / PERCENT_FULL;
            est_hold = (avg_ma != 0) ? bre_pkg::SEC_W'(charge / avg_ma) : '0;
            r.estimate_changed = 1'b1;
            next_slot = (next_slot + 1) % WINDOW;
        end
        else if (filled != 0)
        begin
            // leaving discharge clears the window and invalidates the estimate
            filled = 0;
            next_slot = 0;
            run_sum = 0;
            est_hold = HELD_INVALID;
            r.estimate_changed = 1'b1;
        end
        r.remaining_seconds = est_hold;
        return r;
    endfunction

    function automatic void queue_item(logic dis, logic signed [bre_pkg::CUR_W-1:0] cur,
                                       logic [bre_pkg::PCT_W-1:0] pct, logic typed = 1'b0,
                                       bre_pkg::estimate_t want = '0);
        queued_sample_t q;
        q.smp.discharging = dis;
        q.smp.current_ua = cur;
        q.smp.charge_percent = pct;
        q.typed = typed;
        q.want = want;
        queued_samples.push_back(q);
    endfunction

    // Mostly 0..100; now and then anything the 7-bit field holds.
    function automatic logic [bre_pkg::PCT_W-1:0] pick_percent();
        return ($urandom_range(4) == 0) ? bre_pkg::PCT_W'($urandom())
                                        : bre_pkg::PCT_W'($urandom_range(100));
    endfunction

    // Hold until nothing is queued, on the bus or outstanding. Every item yields one
    // estimate, so an empty store means the block has nothing in work.
    task automatic wait_until_idle();
        while (queued_samples.size() != 0 || sample_valid || pending_estimates.size() != 0)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the edge that ends the access.
    task automatic write_reg(input bre_pkg::cfg_reg_t idx,
                             input logic [bre_pkg::APB_DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Load both registers once the block is idle and mirror them in the predictor.
    task automatic load_config(input logic [bre_pkg::CAP_W-1:0] cap,
                               input logic [bre_pkg::DEF_W-1:0] dflt);
        wait_until_idle();
        write_reg(bre_pkg::REG_CAPACITY, bre_pkg::APB_DATA_W'(cap));
        write_reg(bre_pkg::REG_DEFAULT_CURRENT, bre_pkg::APB_DATA_W'(dflt));
        cap_mah = cap;
        dflt_ua = dflt;
    endtask

    // Build a phase of random items. Most are discharge runs around one current level,
    // long enough to fill and wrap the window or short enough to stay in fill-up; the
    // rest are lone items off discharge and runs ended by a charger being plugged in.
    task automatic queue_random_items(input int count);
        int                               left;
        int                               run_len;
        int                               pick;
        int                               level;
        int                               spread;
        int                               v;
        logic signed [bre_pkg::CUR_W-1:0] cur;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                queue_item(1'b0, bre_pkg::CUR_W'($urandom()), bre_pkg::PCT_W'($urandom()));
                left--;
            end
            else
            begin
                run_len = (pick < 45) ? $urandom_range(300, 650) : $urandom_range(1, 40);
                if (run_len > left)
                    run_len = left;
                // pick the run's level: typical drain, charging, near zero, rails, anything
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    level = $urandom_range(50_000, 2_000_000);
                    spread = 50_000;
                end
                else if (pick < 65)
                begin
                    level = -int'($urandom_range(50_000, 2_000_000));
                    spread = 50_000;
                end
                else if (pick < 80)
                begin
                    level = 0;
                    spread = 400;
                end
                else if (pick < 90)
                begin
                    level = ($urandom_range(1) == 1) ? CUR_MAX : CUR_MIN;
                    spread = 2000;
                end
                else
                begin
                    level = 0;
                    spread = CUR_MAX;
                end
                repeat (run_len)
                begin
                    if ($urandom_range(9) == 0)
                        cur = bre_pkg::CUR_W'($urandom());
                    else
                    begin
                        v = level + int'($urandom_range(2 * spread)) - spread;
                        if (v > CUR_MAX)
                            v = CUR_MAX;
                        if (v < CUR_MIN)
                            v = CUR_MIN;
                        cur = v[bre_pkg::CUR_W-1:0];
                    end
                    queue_item(1'b1, cur, pick_percent());
                end
                left -= run_len;
                if (left > 0 && $urandom_range(3) != 0)
                begin
                    queue_item(1'b0, bre_pkg::CUR_W'($urandom()), pick_percent());
                    left--;
                end
            end
        end
    endtask

    // Sender: on each edge where the bus is free or its item was taken, predict the
    // taken item and either offer the next one or idle. Valid changes once per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample <= '0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            if (sample_valid)
            begin
                predicted = runtime_after_sample(on_bus.smp);
                pending_estimates.push_back(on_bus.typed ? on_bus.want : predicted);
            end
            if (queued_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                on_bus = queued_samples.pop_front();
                sample_valid <= 1'b1;
                sample <= on_bus.smp;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off every so many results so that the
    // block fills up and has to stall its input while the sender keeps offering.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            estimate_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (results_seen >= hold_next)
        begin
            estimate_stall <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            hold_next <= hold_next + HOLD_SPACING;
        end
        else
            estimate_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Checker: compare each taken estimate with the oldest one outstanding.
    always @(posedge clk)
    begin
        if (rst_n && estimate_valid && !estimate_stall)
        begin
            results_seen <= results_seen + 1;
            if (pending_estimates.size() == 0)
            begin
                error_count++;
                $error("unexpected estimate: remaining_seconds %0d, estimate_changed %0b",
                       estimate.remaining_seconds, estimate.estimate_changed);
            end
            else
            begin
                wanted = pending_estimates.pop_front();
                if (estimate.remaining_seconds !== wanted.remaining_seconds)
                begin
                    error_count++;
                    $error("remaining_seconds: expected %0d, got %0d",
                           wanted.remaining_seconds, estimate.remaining_seconds);
                end
                if (estimate.estimate_changed !== wanted.estimate_changed)
                begin
                    error_count++;
                    $error("estimate_changed: expected %0b, got %0b",
                           wanted.estimate_changed, estimate.estimate_changed);
                end
            end
        end
    end

    initial
    begin
        directed_row_t             row;
        bre_pkg::estimate_t        typed_est;
        logic [bre_pkg::CAP_W-1:0] cap;
        logic [bre_pkg::DEF_W-1:0] dflt;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling; a register load drains the block first
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.set_cfg)
                load_config(row.cap, row.dflt);
            typed_est.remaining_seconds = row.want_sec;
            typed_est.estimate_changed = row.want_chg;
            queue_item(row.dis, row.cur, row.pct, row.typed, typed_est);
        end

        // Random phases: reset values, all-ones registers, then random settings, each
        // under its own idling mix. The drain before each load is the sender's pause.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    cap = bre_pkg::CAP_RESET;
                    dflt = bre_pkg::DEFAULT_UA_RESET;
                end
                1:
                begin
                    cap = '1;
                    dflt = '1;
                end
                default:
                begin
                    cap = bre_pkg::CAP_W'($urandom_range(1, 5000));
                    dflt = bre_pkg::DEF_W'($urandom());
                end
            endcase
            load_config(cap, dflt);
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 57;
                end
                default:
                begin
                    send_idle_pct = 18;
                    recv_stall_pct = 18;
                end
            endcase
            queue_random_items(ITEMS_PER_PHASE);
        end

        // Let the last estimates arrive, then watch a while for strays
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: end a run that hangs
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/bre_pkg.sv
rtl/bre_ram.sv
rtl/bre_div.sv
rtl/bre_cfg.sv
rtl/battery_remaining_time_estimator.sv
tb/battery_remaining_time_estimator_tb.sv
